// File: sv/lsm_pkg.sv
// Package for the list-schedule makespan block: sizes, item types, register codes.
package lsm_pkg;

    localparam int MAX_TASKS = 256;
    localparam int MAX_PROCS = 16;
    localparam int MAX_DEPS  = 4;

    localparam int TASK_AW = $clog2(MAX_TASKS);
    localparam int PROC_W  = $clog2(MAX_PROCS);
    localparam int NPROC_W = 5;
    localparam int CNT_W   = 3;
    localparam int TIME_W  = 32;
    localparam int COST_W  = 16;
    localparam int ID_W    = 8;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [NPROC_W-1:0] NUM_PROCS_RST = NPROC_W'(4);
    localparam logic [COST_W-1:0]  NODE_COST_RST = COST_W'(1);
    localparam logic [COST_W-1:0]  COMM_COST_RST = COST_W'(1);

    // Register index, taken from paddr word bits.
    typedef enum logic [1:0] {
        REG_NUM_PROCS = 2'd0,
        REG_NODE_COST = 2'd1,
        REG_COMM_COST = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [ID_W-1:0]  task_id;
        logic [CNT_W-1:0] dep_count;
        logic [ID_W-1:0]  dep_a;
        logic [ID_W-1:0]  dep_b;
        logic [ID_W-1:0]  dep_c;
        logic [ID_W-1:0]  dep_d;
        logic             last_task;
    } t_in_item;

    typedef struct packed {
        logic [3:0]        assigned_proc;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] makespan;
        logic              run_done;
    } t_out_item;

endpackage

// File: sv/list_schedule_makespan.sv
// List-schedule makespan evaluator: task tables, processor table and result register.
// Path: an accepted item loads the work stage while its dependencies are read from
//   the task tables; the work stage then loads the result register, where the result
//   waits until it is taken.
// Throughput: one item per cycle unless output stalls; set by the single work stage.
// Reset (synchronous, active low): processor ready times, rotation and running maximum
//   clear at once; the task tables are not cleared and need no clearing pass.
module list_schedule_makespan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lsm_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lsm_pkg::t_out_item            o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsm_pkg::APB_AW-1:0]    paddr,
    input  logic [lsm_pkg::APB_DW-1:0]    pwdata,
    output logic [lsm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import lsm_pkg::*;

    // One entry of the task tables: processor and finish time kept side by side.
    typedef struct packed {
        logic [PROC_W-1:0] proc;
        logic [TIME_W-1:0] finish;
    } t_task_ent;

    // Saturating add of a cost onto a time.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - COST_W){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NPROC_W-1:0] r_num_procs;
    logic [COST_W-1:0]  r_node_cost;
    logic [COST_W-1:0]  r_comm_cost;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_procs <= NUM_PROCS_RST;
            r_node_cost <= NODE_COST_RST;
            r_comm_cost <= COMM_COST_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_NUM_PROCS: r_num_procs <= pwdata[NPROC_W-1:0];
                REG_NODE_COST: r_node_cost <= pwdata[COST_W-1:0];
                REG_COMM_COST: r_comm_cost <= pwdata[COST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NUM_PROCS: prdata = APB_DW'(r_num_procs);
            REG_NODE_COST: prdata = APB_DW'(r_node_cost);
            REG_COMM_COST: prdata = APB_DW'(r_comm_cost);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic      in_acc;
    logic      s1_adv;
    logic      r_s1_valid;
    t_in_item  r_s1;
    logic [PROC_W-1:0] r_s1_proc;
    logic      r_out_valid;
    t_out_item r_out_item;

    // The work stage moves on whenever the result register is empty or being drained.
    assign s1_adv     = r_s1_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_s1_valid | s1_adv;
    assign in_acc     = i_in_valid & o_in_ready;

    // ------------------------------------------------------------------
    // Round-robin dealing, done as the item is taken in
    // ------------------------------------------------------------------
    logic [NPROC_W-1:0] eff_procs;
    logic [PROC_W-1:0]  r_next_proc;
    logic [PROC_W-1:0]  in_proc;
    logic [NPROC_W-1:0] in_proc_inc;

    always_comb begin
        // Clamp the count: zero acts as one, anything past the table acts as full.
        if (r_num_procs == '0) begin
            eff_procs = NPROC_W'(1);
        end else if (r_num_procs > NPROC_W'(MAX_PROCS)) begin
            eff_procs = NPROC_W'(MAX_PROCS);
        end else begin
            eff_procs = r_num_procs;
        end
        // A rotation left past a lowered count falls back to processor zero.
        in_proc     = (NPROC_W'(r_next_proc) < eff_procs) ? r_next_proc : '0;
        in_proc_inc = NPROC_W'(in_proc) + NPROC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_proc <= '0;
        end else if (in_acc) begin
            if (i_in_item.last_task || (in_proc_inc >= eff_procs)) begin
                r_next_proc <= '0;
            end else begin
                r_next_proc <= in_proc_inc[PROC_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Task tables: two copies, each with two read ports, so all four
    // dependencies are looked up at the edge the item is taken in.
    // ------------------------------------------------------------------
    t_task_ent r_mem_lo [MAX_TASKS];
    t_task_ent r_mem_hi [MAX_TASKS];
    t_task_ent r_rd     [MAX_DEPS];
    logic [TASK_AW-1:0] in_dep_id [MAX_DEPS];
    t_task_ent wr_ent;

    assign in_dep_id[0] = i_in_item.dep_a[TASK_AW-1:0];
    assign in_dep_id[1] = i_in_item.dep_b[TASK_AW-1:0];
    assign in_dep_id[2] = i_in_item.dep_c[TASK_AW-1:0];
    assign in_dep_id[3] = i_in_item.dep_d[TASK_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem_lo[r_s1.task_id[TASK_AW-1:0]] <= wr_ent;
            r_mem_hi[r_s1.task_id[TASK_AW-1:0]] <= wr_ent;
        end
        if (in_acc) begin
            r_rd[0] <= r_mem_lo[in_dep_id[0]];
            r_rd[1] <= r_mem_lo[in_dep_id[1]];
            r_rd[2] <= r_mem_hi[in_dep_id[2]];
            r_rd[3] <= r_mem_hi[in_dep_id[3]];
        end
    end

    // Last write, kept to cover a table read that met a write to the same entry.
    logic               r_lw_valid;
    logic [TASK_AW-1:0] r_lw_tid;
    t_task_ent          r_lw_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
        end else if (s1_adv) begin
            r_lw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_lw_tid <= r_s1.task_id[TASK_AW-1:0];
            r_lw_ent <= wr_ent;
        end
    end

    // ------------------------------------------------------------------
    // Work stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1      <= i_in_item;
            r_s1_proc <= in_proc;
        end
    end

    logic [TIME_W-1:0]  r_proc_ready [MAX_PROCS];
    logic [TIME_W-1:0]  r_running_max;
    logic [TASK_AW-1:0] s1_dep_id [MAX_DEPS];
    t_task_ent          s1_dep [MAX_DEPS];
    logic [TIME_W-1:0]  s1_arrive [MAX_DEPS];
    logic [CNT_W-1:0]   s1_cnt;
    logic [TIME_W-1:0]  s1_start;
    logic [TIME_W-1:0]  s1_finish;
    logic [TIME_W-1:0]  s1_makespan;

    assign s1_dep_id[0] = r_s1.dep_a[TASK_AW-1:0];
    assign s1_dep_id[1] = r_s1.dep_b[TASK_AW-1:0];
    assign s1_dep_id[2] = r_s1.dep_c[TASK_AW-1:0];
    assign s1_dep_id[3] = r_s1.dep_d[TASK_AW-1:0];

    // Take the freshest copy of each dependency and its arrival time here.
    always_comb begin
        for (int k = 0; k < MAX_DEPS; k++) begin
            if (r_lw_valid && (r_lw_tid == s1_dep_id[k])) begin
                s1_dep[k] = r_lw_ent;
            end else begin
                s1_dep[k] = r_rd[k];
            end
            s1_arrive[k] = sat_add(s1_dep[k].finish, r_comm_cost);
        end
    end

    // Start at the later of the processor's ready time and each remote arrival.
    always_comb begin
        s1_cnt = (r_s1.dep_count > CNT_W'(MAX_DEPS)) ? CNT_W'(MAX_DEPS) : r_s1.dep_count;
        s1_start = r_proc_ready[r_s1_proc];
        for (int k = 0; k < MAX_DEPS; k++) begin
            if ((CNT_W'(k) < s1_cnt) && (s1_dep[k].proc != r_s1_proc)
                && (s1_arrive[k] > s1_start)) begin
                s1_start = s1_arrive[k];
            end
        end
        s1_finish   = sat_add(s1_start, r_node_cost);
        s1_makespan = (s1_finish > r_running_max) ? s1_finish : r_running_max;
    end

    assign wr_ent.proc   = r_s1_proc;
    assign wr_ent.finish = s1_finish;

    // Update the processor table and the running maximum; a last item wipes the run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < MAX_PROCS; p++) begin
                r_proc_ready[p] <= '0;
            end
            r_running_max <= '0;
        end else if (s1_adv) begin
            if (r_s1.last_task) begin
                for (int p = 0; p < MAX_PROCS; p++) begin
                    r_proc_ready[p] <= '0;
                end
                r_running_max <= '0;
            end else begin
                r_proc_ready[r_s1_proc] <= s1_finish;
                r_running_max           <= s1_makespan;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item.assigned_proc <= 4'(r_s1_proc);
            r_out_item.finish_time   <= s1_finish;
            r_out_item.makespan      <= s1_makespan;
            r_out_item.run_done      <= r_s1.last_task;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rotation_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.last_task) |=> (r_next_proc == '0))
        else $error("rotation not restarted after the last item of a run");

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1.last_task) |=> (r_running_max == '0) && (r_proc_ready[0] == '0))
        else $error("run state not cleared after the last item");

    a_makespan_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.makespan >= o_out_item.finish_time))
        else $error("makespan below the finish time of its own item");

    a_finish_after_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |-> (s1_finish >= r_proc_ready[r_s1_proc]))
        else $error("task finishes before its processor is free");

endmodule
